[src/pcd_pkg.sv]
package pcd_pkg;

  localparam int ELEM_W     = 4;   // element / image value width
  localparam int CYC_W      = 5;   // cycle count and run length width
  localparam int VALUE_SPAN = 16;  // number of distinct element codes

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_CHECK,
    ST_SEEK,
    ST_EMIT
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic load;   // input transaction: store image, update maps
    logic check;  // latch run length
    logic err;    // emit the error result
    logic seek;   // pick lowest unvisited element, read its image
    logic emit;   // emit current element, follow the link
    logic clear;  // end of run: drop per-run state
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic perm_ok;    // loaded values form a permutation
    logic slot_free;  // output register can take a result
    logic closes;     // image of current element is the cycle start
    logic final_el;   // current element is the last one of the run
  } sts_t;

endpackage

[src/pcd_if.sv]
interface pcd_in_if;
  logic                        valid;
  logic                        ready;
  logic [pcd_pkg::ELEM_W-1:0] image_value;
  logic                        load_last;

  modport source (output valid, output image_value, output load_last, input ready);
  modport sink   (input valid, input image_value, input load_last, output ready);
endinterface

interface pcd_out_if;
  logic                        valid;
  logic                        ready;
  logic [pcd_pkg::ELEM_W-1:0] cycle_element;
  logic                        cycle_end;
  logic                        run_last;
  logic [pcd_pkg::CYC_W-1:0]  total_cycles;
  logic                        odd_parity;
  logic                        bad_input;

  modport source (output valid, output cycle_element, output cycle_end, output run_last,
                  output total_cycles, output odd_parity, output bad_input, input ready);
  modport sink   (input valid, input cycle_element, input cycle_end, input run_last,
                  input total_cycles, input odd_parity, input bad_input, output ready);
endinterface

[src/permutation_cycle_decomposer.sv]
// Permutation cycle decomposer. Load a permutation of 0..n-1 one image value per
// input transaction, marking the final position with load_last; n may be up to
// min(MAX_ELEMENTS, 16). The block then returns one result per element in cycle
// order: each cycle starts at the lowest unvisited element and follows image
// links, cycle_end flags the element that closes a cycle, and the final result
// carries run_last, total_cycles and the parity ((n - total_cycles) mod 2). A load
// that is not a permutation, or that overruns MAX_ELEMENTS entries, yields a single
// result with bad_input set instead. After the last transaction the block checks
// the load, then for each cycle found picks its start and emits its elements.
// The element walk is bound by the image store's single registered read port:
// each read returns the address of the next one. Input is refused while the
// decomposition runs; the result register lets a new load begin while the last
// result still waits to be taken.
module permutation_cycle_decomposer #(
  parameter int MAX_ELEMENTS = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  pcd_in_if.sink    in_chan,
  pcd_out_if.source out_chan
);
  import pcd_pkg::*;

  cmd_t cmd;
  sts_t sts;

  pcd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_last  (in_chan.load_last),
    .in_ready (in_chan.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  pcd_dpath #(
    .MAX_ELEMENTS (MAX_ELEMENTS)
  ) u_dpath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .in_image_value    (in_chan.image_value),
    .out_ready         (out_chan.ready),
    .out_valid         (out_chan.valid),
    .out_cycle_element (out_chan.cycle_element),
    .out_cycle_end     (out_chan.cycle_end),
    .out_run_last      (out_chan.run_last),
    .out_total_cycles  (out_chan.total_cycles),
    .out_odd_parity    (out_chan.odd_parity),
    .out_bad_input     (out_chan.bad_input)
  );

endmodule

[src/pcd_ram.sv]
module pcd_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

[src/pcd_ctrl.sv]
module pcd_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic          in_last,
  output logic          in_ready,
  input  pcd_pkg::sts_t sts,
  output pcd_pkg::cmd_t cmd
);
  import pcd_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_LOAD: begin
        if (in_valid && in_last) state_nxt = ST_CHECK;
      end
      ST_CHECK: begin
        if (sts.perm_ok)        state_nxt = ST_SEEK;
        else if (sts.slot_free) state_nxt = ST_LOAD;
      end
      ST_SEEK: begin
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (sts.slot_free) begin
          if (sts.final_el)    state_nxt = ST_LOAD;
          else if (sts.closes) state_nxt = ST_SEEK;
        end
      end
      default: state_nxt = ST_LOAD;
    endcase
  end

  always_comb begin
    in_ready  = (state_r == ST_LOAD);
    cmd.load  = (state_r == ST_LOAD) && in_valid;
    cmd.check = (state_r == ST_CHECK);
    cmd.err   = (state_r == ST_CHECK) && !sts.perm_ok && sts.slot_free;
    cmd.seek  = (state_r == ST_SEEK);
    cmd.emit  = (state_r == ST_EMIT) && sts.slot_free;
    cmd.clear = cmd.err || (cmd.emit && sts.final_el);
  end

endmodule

[src/pcd_dpath.sv]
module pcd_dpath #(
  parameter int MAX_ELEMENTS = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  pcd_pkg::cmd_t               cmd,
  output pcd_pkg::sts_t               sts,
  input  logic [pcd_pkg::ELEM_W-1:0]  in_image_value,
  input  logic                        out_ready,
  output logic                        out_valid,
  output logic [pcd_pkg::ELEM_W-1:0]  out_cycle_element,
  output logic                        out_cycle_end,
  output logic                        out_run_last,
  output logic [pcd_pkg::CYC_W-1:0]   out_total_cycles,
  output logic                        out_odd_parity,
  output logic                        out_bad_input
);
  import pcd_pkg::*;

  localparam int CNT_W  = $clog2(MAX_ELEMENTS + 1);
  localparam int ADDR_W = $clog2(MAX_ELEMENTS);

  // per-run state
  logic [CNT_W-1:0]      cnt_r;
  logic [VALUE_SPAN-1:0] seen_r;
  logic [VALUE_SPAN-1:0] visited_r;
  logic                  ovf_r;
  logic [CYC_W-1:0]      len_r;
  logic [CYC_W-1:0]      k_r;
  logic [CYC_W-1:0]      cyc_r;
  logic [ELEM_W-1:0]     start_r;
  logic [ELEM_W-1:0]     cur_r;

  // output register
  logic                  out_valid_r;
  logic [ELEM_W-1:0]     elem_r;
  logic                  end_r;
  logic                  last_r;
  logic [CYC_W-1:0]      tc_r;
  logic                  odd_r;
  logic                  bad_r;

  logic                  store_full;
  logic [VALUE_SPAN-1:0] len_mask;
  logic [ELEM_W-1:0]     first_free;
  logic [ELEM_W-1:0]     rd_data;
  logic [ADDR_W-1:0]     rd_addr;
  logic                  rd_en;
  logic                  wr_en;
  logic                  end_flag;
  logic [CYC_W-1:0]      cyc_inc;

  assign store_full = (cnt_r == CNT_W'(MAX_ELEMENTS));

  always_comb begin
    for (int i = 0; i < VALUE_SPAN; i++) begin
      len_mask[i] = (32'(cnt_r) > i);
    end
  end

  // lowest unvisited element
  always_comb begin
    first_free = '0;
    for (int i = VALUE_SPAN - 1; i >= 0; i--) begin
      if (!visited_r[i]) first_free = ELEM_W'(i);
    end
  end

  assign sts.perm_ok   = !ovf_r && (32'(cnt_r) <= VALUE_SPAN) && (seen_r == len_mask);
  assign sts.slot_free = !out_valid_r || out_ready;
  assign sts.closes    = (rd_data == start_r);
  assign sts.final_el  = ((k_r + CYC_W'(1)) == len_r);

  assign end_flag = sts.closes || sts.final_el;
  assign cyc_inc  = cyc_r + CYC_W'(1);

  assign wr_en   = cmd.load && !store_full;
  assign rd_en   = cmd.seek || (cmd.emit && !end_flag);
  assign rd_addr = cmd.seek ? ADDR_W'(first_free) : ADDR_W'(rd_data);

  pcd_ram #(
    .WIDTH (ELEM_W),
    .DEPTH (MAX_ELEMENTS)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (ADDR_W'(cnt_r)),
    .wr_data (in_image_value),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r     <= '0;
      seen_r    <= '0;
      visited_r <= '0;
      ovf_r     <= 1'b0;
      k_r       <= '0;
      cyc_r     <= '0;
    end else if (cmd.clear) begin
      cnt_r     <= '0;
      seen_r    <= '0;
      visited_r <= '0;
      ovf_r     <= 1'b0;
      k_r       <= '0;
      cyc_r     <= '0;
    end else begin
      if (cmd.load) begin
        if (store_full) ovf_r <= 1'b1;
        else            cnt_r <= cnt_r + CNT_W'(1);
        seen_r[in_image_value] <= 1'b1;
      end
      if (cmd.emit) begin
        visited_r[cur_r] <= 1'b1;
        k_r              <= k_r + CYC_W'(1);
        if (end_flag) cyc_r <= cyc_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.check) begin
      len_r <= CYC_W'(cnt_r);
    end
    if (cmd.seek) begin
      start_r <= first_free;
      cur_r   <= first_free;
    end else if (cmd.emit && !end_flag) begin
      cur_r <= rd_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.err || cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.err) begin
      elem_r <= '0;
      end_r  <= 1'b0;
      last_r <= 1'b1;
      tc_r   <= '0;
      odd_r  <= 1'b0;
      bad_r  <= 1'b1;
    end else if (cmd.emit) begin
      elem_r <= cur_r;
      end_r  <= end_flag;
      last_r <= sts.final_el;
      tc_r   <= sts.final_el ? cyc_inc : '0;
      odd_r  <= sts.final_el && (len_r[0] ^ cyc_inc[0]);
      bad_r  <= 1'b0;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_cycle_element = elem_r;
  assign out_cycle_end     = end_r;
  assign out_run_last      = last_r;
  assign out_total_cycles  = tc_r;
  assign out_odd_parity    = odd_r;
  assign out_bad_input     = bad_r;

endmodule

[src/pcd_checker.sv]
module pcd_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        in_load_last,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [pcd_pkg::ELEM_W-1:0]  out_cycle_element,
  input logic                        out_cycle_end,
  input logic                        out_run_last,
  input logic [pcd_pkg::CYC_W-1:0]   out_total_cycles,
  input logic                        out_odd_parity,
  input logic                        out_bad_input
);
  import pcd_pkg::*;

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_cycle_element)
      && $stable(out_cycle_end) && $stable(out_run_last) && $stable(out_bad_input))
    else $error("result changed while stalled");

  // last load transaction starts the run: input refused next cycle
  a_last_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_load_last |=> !in_ready)
    else $error("input accepted right after final load");

  // count and parity only on the final result
  a_summary_final: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_run_last |-> out_total_cycles == '0 && !out_odd_parity
      && !out_bad_input)
    else $error("summary fields on non-final result");

  // error result shape
  a_err_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_bad_input |-> out_run_last && !out_cycle_end
      && out_cycle_element == '0 && out_total_cycles == '0)
    else $error("malformed error result");

  // a good run always ends by closing a cycle
  a_final_closes: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_run_last && !out_bad_input |-> out_cycle_end
      && out_total_cycles != '0)
    else $error("final result does not close a cycle");

endmodule

bind permutation_cycle_decomposer pcd_checker u_pcd_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_chan.valid),
  .in_ready          (in_chan.ready),
  .in_load_last      (in_chan.load_last),
  .out_valid         (out_chan.valid),
  .out_ready         (out_chan.ready),
  .out_cycle_element (out_chan.cycle_element),
  .out_cycle_end     (out_chan.cycle_end),
  .out_run_last      (out_chan.run_last),
  .out_total_cycles  (out_chan.total_cycles),
  .out_odd_parity    (out_chan.odd_parity),
  .out_bad_input     (out_chan.bad_input)
);

[tb/sv/permutation_cycle_decomposer_tb.sv]
`timescale 1ns / 100ps

// Loads permutations (and loads that are not permutations) into the decomposer
// and checks every result transaction against a prediction made here. A short
// table of directed loads comes first. Random runs follow, with the sender
// working in bursts, the receiver stalling on shifting patterns, one long
// receiver hold-off and periodic drains of the result stream.
module permutation_cycle_decomposer_tb;
  import pcd_pkg::*;

  localparam int STORE_DEPTH    = 16;    // image store entries in the block
  localparam int ITEM_TARGET    = 410;   // input transactions before stimulus stops
  localparam int HOLD_CYCLES    = 200;   // long receiver hold-off
  localparam int WATCHDOG_LIMIT = 2000;  // cycles without any transaction
  localparam int TAIL_CYCLES    = 40;    // settle time after the last result

  // One result transaction, field for field.
  typedef struct packed {
    logic [ELEM_W-1:0] cycle_element;
    logic              cycle_end;
    logic              run_last;
    logic [CYC_W-1:0]  total_cycles;
    logic              odd_parity;
    logic              bad_input;
  } cycle_rec_t;

  // Directed load: one input transaction, plus a typed-in result where the
  // answer is plain (fixed point alone, rejected loads).
  typedef struct packed {
    logic [ELEM_W-1:0] image_value;
    logic              load_last;
    logic              typed;
    cycle_rec_t        want;
  } load_row_t;

  typedef enum logic [1:0] {
    RX_FREE,     // always ready
    RX_PATTERN,  // rotating 8-bit mask
    RX_SPARSE,   // ready about one cycle in four
    RX_COIN      // ready half the time
  } rx_mode_t;

  localparam cycle_rec_t NO_REC     = '0;
  localparam cycle_rec_t BAD_LOAD   = '{cycle_element: '0, cycle_end: 1'b0, run_last: 1'b1,
                                        total_cycles: '0, odd_parity: 1'b0,
                                        bad_input: 1'b1};
  localparam cycle_rec_t SOLO_FIXED = '{cycle_element: '0, cycle_end: 1'b1, run_last: 1'b1,
                                        total_cycles: 5'd1, odd_parity: 1'b0,
                                        bad_input: 1'b0};

  // Directed loads:
  //   single fixed point, lone value out of range, a swap (walked by the
  //   predictor), duplicate top value, then a full reversed load of 16 entries
  //   followed by one more entry, which overruns the store.
  localparam load_row_t DIRECTED_LOADS [0:22] = '{
    '{4'd0,  1'b1, 1'b1, SOLO_FIXED},
    '{4'd1,  1'b1, 1'b1, BAD_LOAD},
    '{4'd1,  1'b0, 1'b0, NO_REC},
    '{4'd0,  1'b1, 1'b0, NO_REC},
    '{4'd15, 1'b0, 1'b0, NO_REC},
    '{4'd15, 1'b1, 1'b1, BAD_LOAD},
    '{4'd15, 1'b0, 1'b0, NO_REC},
    '{4'd14, 1'b0, 1'b0, NO_REC},
    '{4'd13, 1'b0, 1'b0, NO_REC},
    '{4'd12, 1'b0, 1'b0, NO_REC},
    '{4'd11, 1'b0, 1'b0, NO_REC},
    '{4'd10, 1'b0, 1'b0, NO_REC},
    '{4'd9,  1'b0, 1'b0, NO_REC},
    '{4'd8,  1'b0, 1'b0, NO_REC},
    '{4'd7,  1'b0, 1'b0, NO_REC},
    '{4'd6,  1'b0, 1'b0, NO_REC},
    '{4'd5,  1'b0, 1'b0, NO_REC},
    '{4'd4,  1'b0, 1'b0, NO_REC},
    '{4'd3,  1'b0, 1'b0, NO_REC},
    '{4'd2,  1'b0, 1'b0, NO_REC},
    '{4'd1,  1'b0, 1'b0, NO_REC},
    '{4'd0,  1'b0, 1'b0, NO_REC},
    '{4'd0,  1'b1, 1'b1, BAD_LOAD}
  };

  logic clk;
  logic rst_n;

  pcd_in_if  in_chan ();
  pcd_out_if out_chan ();

  permutation_cycle_decomposer #(
    .MAX_ELEMENTS (STORE_DEPTH)
  ) i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  // Predictor state: mirror of the load in progress.
  logic [ELEM_W-1:0]     perm_img [STORE_DEPTH];
  int                    perm_len;
  logic [VALUE_SPAN-1:0] perm_seen;
  logic                  perm_overrun;

  cycle_rec_t cycles_due [$];  // results still owed by the block, oldest first
  int         mismatches;
  int         items_sent;
  int         burst_left;
  int         quiet_cycles;
  bit         hold_off_due;    // raised by the sender, served by the receiver

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Take one accepted image value into the mirror. On the last position, work
  // out the whole decomposition (or the error result) and queue it.
  task automatic absorb_image(input logic [ELEM_W-1:0] img, input logic is_last,
                              input logic typed, input cycle_rec_t typed_rec);
    logic [VALUE_SPAN:0]   full_set;
    logic [VALUE_SPAN-1:0] visited;
    logic [ELEM_W-1:0]     cur;
    logic [ELEM_W-1:0]     nxt;
    cycle_rec_t            walk [$];
    cycle_rec_t            rec;
    int                    n;
    int                    ncyc;
    begin
      if (perm_len < STORE_DEPTH) begin
        perm_img[perm_len] = img;
        perm_len++;
      end else begin
        perm_overrun = 1'b1;  // store full: value dropped, run is spoiled
      end
      perm_seen[img] = 1'b1;
      if (!is_last) return;

      n        = perm_len;
      full_set = (17'd1 << n) - 17'd1;
      if (typed) begin
        cycles_due.push_back(typed_rec);
      end else if (perm_overrun || perm_seen != full_set[VALUE_SPAN-1:0]) begin
        cycles_due.push_back(BAD_LOAD);
      end else begin
        // Lowest unvisited element starts each cycle; follow images until
        // the link points back at the start.
        visited = '0;
        ncyc    = 0;
        for (int start = 0; start < n; start++) begin
          if (visited[start]) continue;
          cur = ELEM_W'(start);
          forever begin
            visited[cur] = 1'b1;
            nxt          = perm_img[cur];
            rec          = NO_REC;
            rec.cycle_element = cur;
            if (nxt == ELEM_W'(start)) begin
              rec.cycle_end = 1'b1;
              ncyc++;
              walk.push_back(rec);
              break;
            end
            walk.push_back(rec);
            cur = nxt;
          end
        end
        walk[walk.size()-1].run_last     = 1'b1;
        walk[walk.size()-1].total_cycles = CYC_W'(ncyc);
        walk[walk.size()-1].odd_parity   = 1'((n - ncyc) & 1);
        foreach (walk[i]) cycles_due.push_back(walk[i]);
      end
      perm_len     = 0;
      perm_seen    = '0;
      perm_overrun = 1'b0;
    end
  endtask

  // Offer one image value and hold it until the block takes it. The sender
  // works in bursts; at the end of a burst valid drops for a random gap.
  task automatic offer_image(input logic [ELEM_W-1:0] img, input logic is_last,
                             input logic typed, input cycle_rec_t typed_rec);
    begin
      in_chan.valid       <= 1'b1;
      in_chan.image_value <= img;
      in_chan.load_last   <= is_last;
      do @(posedge clk); while (!in_chan.ready);
      absorb_image(img, is_last, typed, typed_rec);
      items_sent++;
      if (burst_left > 0) burst_left--;
      if (burst_left == 0) begin
        in_chan.valid <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
        // now and then a long run with no gaps at all
        burst_left = ($urandom_range(0, 3) == 0) ? 64 : $urandom_range(1, 16);
      end
    end
  endtask

  // Sender pause: nothing offered until every owed result has been taken.
  task automatic drain_results;
    begin
      in_chan.valid <= 1'b0;
      @(posedge clk);
      while (cycles_due.size() != 0) @(posedge clk);
    end
  endtask

  // Stimulus
  initial begin : stimulus
    logic [ELEM_W-1:0] run_vals [$];
    logic [ELEM_W-1:0] tmp;
    int                kind;
    int                n;
    int                j;
    int                run_idx;
    bit                hold_done;

    rst_n               <= 1'b0;
    in_chan.valid       <= 1'b0;
    in_chan.image_value <= '0;
    in_chan.load_last   <= 1'b0;
    perm_len     = 0;
    perm_seen    = '0;
    perm_overrun = 1'b0;
    mismatches   = 0;
    items_sent   = 0;
    burst_left   = $urandom_range(1, 16);
    hold_off_due = 1'b0;
    hold_done    = 1'b0;
    run_idx      = 0;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // directed table
    foreach (DIRECTED_LOADS[i])
      offer_image(DIRECTED_LOADS[i].image_value, DIRECTED_LOADS[i].load_last,
                  DIRECTED_LOADS[i].typed, DIRECTED_LOADS[i].want);
    drain_results();

    // random runs
    while (items_sent < ITEM_TARGET) begin
      kind = $urandom_range(0, 99);
      // first random run is a full-size permutation; sizes lean small
      if (run_idx == 0)                      n = STORE_DEPTH;
      else if ($urandom_range(0, 1) == 0)    n = $urandom_range(1, 5);
      else                                   n = $urandom_range(1, STORE_DEPTH);

      run_vals.delete();
      for (int i = 0; i < n; i++) run_vals.push_back(ELEM_W'(i));
      for (int i = n - 1; i > 0; i--) begin
        j           = $urandom_range(0, i);
        tmp         = run_vals[i];
        run_vals[i] = run_vals[j];
        run_vals[j] = tmp;
      end

      if (run_idx != 0) begin
        if (kind >= 70 && kind < 80) begin
          // one entry replaced by anything
          run_vals[$urandom_range(0, n - 1)] = ELEM_W'($urandom_range(0, 15));
        end else if (kind >= 80 && kind < 88) begin
          // pure noise
          foreach (run_vals[i]) run_vals[i] = ELEM_W'($urandom_range(0, 15));
        end else if (kind >= 88 && kind < 94 && n < STORE_DEPTH) begin
          // one value at or above the load length
          run_vals[$urandom_range(0, n - 1)] = ELEM_W'($urandom_range(n, 15));
        end else if (kind >= 94) begin
          // overrun: a full permutation and then a few more entries
          run_vals.delete();
          for (int i = 0; i < STORE_DEPTH; i++) run_vals.push_back(ELEM_W'(i));
          for (int i = STORE_DEPTH - 1; i > 0; i--) begin
            j           = $urandom_range(0, i);
            tmp         = run_vals[i];
            run_vals[i] = run_vals[j];
            run_vals[j] = tmp;
          end
          repeat ($urandom_range(1, 3)) run_vals.push_back(ELEM_W'($urandom_range(0, 15)));
        end
      end

      // once: receiver holds off while loads keep coming, so the result
      // register fills and the input side backs up
      if (!hold_done && items_sent >= 150) begin
        hold_off_due = 1'b1;
        hold_done    = 1'b1;
      end

      foreach (run_vals[i])
        offer_image(run_vals[i], (i == run_vals.size() - 1), 1'b0, NO_REC);

      if (run_idx % 20 == 19) drain_results();
      run_idx++;
    end

    in_chan.valid <= 1'b0;
    @(posedge clk);
    while (cycles_due.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (mismatches == 0) begin
      $display("permutation_cycle_decomposer regression: pass");
    end else begin
      $display("permutation_cycle_decomposer regression: fail");
    end
    $finish;
  end

  // Receiver: stalls on a mode picked at random for each stretch; serves the
  // long hold-off when the sender asks for it.
  initial begin : receiver
    rx_mode_t    mode;
    logic [7:0]  pattern;
    int          stretch;

    out_chan.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      mode    = rx_mode_t'($urandom_range(0, 3));
      pattern = 8'($urandom) | 8'h01;  // never an all-stall mask
      stretch = $urandom_range(16, 64);
      repeat (stretch) begin
        if (hold_off_due) begin
          hold_off_due = 1'b0;
          out_chan.ready <= 1'b0;
          repeat (HOLD_CYCLES) @(posedge clk);
        end
        case (mode)
          RX_FREE: begin
            out_chan.ready <= 1'b1;
          end
          RX_PATTERN: begin
            out_chan.ready <= pattern[0];
            pattern = {pattern[0], pattern[7:1]};
          end
          RX_SPARSE: begin
            out_chan.ready <= ($urandom_range(0, 3) == 0);
          end
          default: begin
            out_chan.ready <= 1'($urandom_range(0, 1));
          end
        endcase
        @(posedge clk);
      end
    end
  end

  // Result checker: each result transaction against the oldest owed result.
  always @(posedge clk) begin
    cycle_rec_t want;
    if (rst_n && out_chan.valid && out_chan.ready) begin
      if (cycles_due.size() == 0) begin
        $error("unexpected result transaction: cycle_element %0d run_last %0d",
               out_chan.cycle_element, out_chan.run_last);
        mismatches++;
      end else begin
        want = cycles_due.pop_front();
        if (out_chan.cycle_element !== want.cycle_element) begin
          $error("cycle_element: expected %0d, got %0d", want.cycle_element,
                 out_chan.cycle_element);
          mismatches++;
        end
        if (out_chan.cycle_end !== want.cycle_end) begin
          $error("cycle_end: expected %0d, got %0d", want.cycle_end, out_chan.cycle_end);
          mismatches++;
        end
        if (out_chan.run_last !== want.run_last) begin
          $error("run_last: expected %0d, got %0d", want.run_last, out_chan.run_last);
          mismatches++;
        end
        if (out_chan.total_cycles !== want.total_cycles) begin
          $error("total_cycles: expected %0d, got %0d", want.total_cycles,
                 out_chan.total_cycles);
          mismatches++;
        end
        if (out_chan.odd_parity !== want.odd_parity) begin
          $error("odd_parity: expected %0d, got %0d", want.odd_parity, out_chan.odd_parity);
          mismatches++;
        end
        if (out_chan.bad_input !== want.bad_input) begin
          $error("bad_input: expected %0d, got %0d", want.bad_input, out_chan.bad_input);
          mismatches++;
        end
      end
    end
  end

  // Watchdog: too long without a transaction on either side means a hang.
  always @(posedge clk) begin
    if ((in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("permutation_cycle_decomposer regression: fail");
      $finish;
    end
  end

  initial quiet_cycles = 0;

endmodule
